@@ rtl/polpq_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// polpq_pkg: shared types and constants for the per-link packet queues
// Sizes, operation and status codes, and the records that pass between the
// front end and the back end of the queue manager.
// ----------------------------------------------------------------------------
package polpq_pkg;

  localparam int QUEUE_SLOTS = 128;
  localparam int QUEUE_DEPTH = 128;
  localparam int LINK_BITS   = 8;

  localparam int SLOT_W    = $clog2(QUEUE_SLOTS);
  localparam int POS_W     = $clog2(QUEUE_DEPTH);
  localparam int DEPTH_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int LINKS     = 1 << LINK_BITS;
  localparam int PKT_DEPTH = QUEUE_SLOTS << POS_W;
  localparam int PKT_AW    = SLOT_W + POS_W;

  typedef logic [LINK_BITS-1:0] link_t;
  typedef logic [SLOT_W-1:0]    slot_t;
  typedef logic [POS_W-1:0]     pos_t;
  typedef logic [DEPTH_W-1:0]   depth_t;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_QUERY = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NO_ROUTE = 3'd1,
    ST_NO_SLOT  = 3'd2,
    ST_FULL     = 3'd3,
    ST_ABSENT   = 3'd4
  } status_e;

  // Classified command handed from the front end to the back end.
  typedef struct packed {
    op_e         op;
    link_t       link;
    logic [31:0] addr;
    logic        hit;     // link already owns a slot
    logic        nofree;  // new link and every slot taken
    slot_t       slot;    // owning slot, or the free slot to claim
  } item_t;

  // Slot table changes sent from the back end to the front end.
  typedef struct packed {
    logic  claim;
    logic  free;
    logic  clear_all;
    slot_t slot;
    link_t link;
  } upd_t;

  // Per-slot queue bookkeeping.
  typedef struct packed {
    depth_t depth;
    pos_t   head;
    pos_t   tail;
  } slot_rec_t;

  // Advance a ring position with wraparound at the queue depth.
  function automatic pos_t next_pos(input pos_t p);
    next_pos = (p == pos_t'(QUEUE_DEPTH - 1)) ? '0 : pos_t'(p + 1'b1);
  endfunction

endpackage
`default_nettype wire

@@ rtl/per_output_link_packet_queues.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// per_output_link_packet_queues: per-link packet address queues
// A pool of queue slots, each bound to one output link and holding a FIFO
// of packet addresses; push, pop, depth query and clear-all.
// ----------------------------------------------------------------------------
// Usage:
// A command (operation_i, link_number_i, packet_addr_i) is taken at a clock
// edge where start is high and busy is low. busy then stays high until the
// command's single result has been delivered.
// The result (status_o, popped_addr_o, queue_count_o) is shown for exactly
// one cycle with result_valid_o high; the receiver cannot stall it.
// The result strobe follows the map lookup, the slot record read-modify-write
// and, for a pop that returns an address, an extra packet store read; each
// is a registered RAM access. One command is in flight at a time: a new one
// is taken only after the last result has been delivered.
// Slot lookup uses a link-to-slot map with a valid bit per link and a valid
// bit per slot; the lowest free slot is kept in a register.
// Reset clears all valid bits at once, so every queue starts empty with no
// clearing pass; the slot records and packet store need no reset.
// ----------------------------------------------------------------------------
module per_output_link_packet_queues (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         start,
  output logic        busy,
  input  wire  [1:0]  operation_i,
  input  wire  [7:0]  link_number_i,
  input  wire  [31:0] packet_addr_i,
  output logic        result_valid_o,
  output logic [2:0]  status_o,
  output logic [31:0] popped_addr_o,
  output logic [7:0]  queue_count_o
);

  logic             fifo_push, fifo_pop, fifo_empty;
  polpq_pkg::item_t front_item, back_item;
  polpq_pkg::upd_t  upd;

  // Intake and classification.
  polpq_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .operation_i   (operation_i),
    .link_number_i (link_number_i),
    .packet_addr_i (packet_addr_i),
    .done_i        (result_valid_o),
    .upd_i         (upd),
    .push_o        (fifo_push),
    .item_o        (front_item)
  );

  // Queue between the two halves.
  polpq_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fifo_push),
    .item_i  (front_item),
    .pop_i   (fifo_pop),
    .item_o  (back_item),
    .empty_o (fifo_empty)
  );

  // Execution and result delivery.
  polpq_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .empty_i  (fifo_empty),
    .item_i   (back_item),
    .pop_o    (fifo_pop),
    .upd_o    (upd),
    .done_o   (result_valid_o),
    .status_o (status_o),
    .popped_o (popped_addr_o),
    .count_o  (queue_count_o)
  );

endmodule
`default_nettype wire

@@ rtl/polpq_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// polpq_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module polpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire                      clk_i,
  input  wire                      we_i,
  input  wire  [$clog2(DEPTH)-1:0] waddr_i,
  input  wire  [WIDTH-1:0]         wdata_i,
  input  wire  [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

@@ rtl/polpq_fifo.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// polpq_fifo: two-entry queue of classified commands
// Decouples the front end from the back end.
// ----------------------------------------------------------------------------
module polpq_fifo (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    push_i,
  input  wire polpq_pkg::item_t  item_i,
  input  wire                    pop_i,
  output polpq_pkg::item_t       item_o,
  output logic                   empty_o
);

  polpq_pkg::item_t ent_q [2];
  logic             wr_q, rd_q;
  logic [1:0]       cnt_q;

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_q] <= item_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  assign item_o  = ent_q[rd_q];
  assign empty_o = (cnt_q == 2'd0);

endmodule
`default_nettype wire

@@ rtl/polpq_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// polpq_front: command intake and link classification
// Accepts a command, looks its link up in the link-to-slot map and picks
// the lowest free slot, then queues the classified command.
// ----------------------------------------------------------------------------
module polpq_front (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    start,
  output logic                   busy,
  input  wire  [1:0]             operation_i,
  input  wire  [7:0]             link_number_i,
  input  wire  [31:0]            packet_addr_i,
  input  wire                    done_i,
  input  wire polpq_pkg::upd_t   upd_i,
  output logic                   push_o,
  output polpq_pkg::item_t       item_o
);

  logic                          busy_q, lookup_q;
  polpq_pkg::op_e                op_q;
  polpq_pkg::link_t              link_q;
  logic [31:0]                   addr_q;
  logic [polpq_pkg::LINKS-1:0]   map_valid_q;
  logic [polpq_pkg::QUEUE_SLOTS-1:0] slot_valid_q;
  polpq_pkg::slot_t              free_slot_q, free_slot_d;
  logic                          free_ok_q, free_ok_d;
  polpq_pkg::slot_t              map_rdata;
  polpq_pkg::link_t              in_link;
  logic                          accept, hit;

  assign accept  = start && !busy_q;
  assign busy    = busy_q;
  assign in_link = polpq_pkg::link_t'(link_number_i);

  // Link-to-slot map; entries are meaningful only while their valid bit is set.
  polpq_ram #(
    .WIDTH (polpq_pkg::SLOT_W),
    .DEPTH (polpq_pkg::LINKS)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (upd_i.claim),
    .waddr_i (upd_i.link),
    .wdata_i (upd_i.slot),
    .raddr_i (in_link),
    .rdata_o (map_rdata)
  );

  // Lowest free slot, registered from the valid bits.
  always_comb begin
    free_slot_d = '0;
    free_ok_d   = 1'b0;
    for (int s = polpq_pkg::QUEUE_SLOTS - 1; s >= 0; s--) begin
      if (!slot_valid_q[s]) begin
        free_slot_d = polpq_pkg::slot_t'(s);
        free_ok_d   = 1'b1;
      end
    end
  end

  // Classification of the command captured in the previous cycle.
  assign hit    = map_valid_q[link_q] && (link_q != '0);
  assign push_o = lookup_q;
  always_comb begin
    item_o.op     = op_q;
    item_o.link   = link_q;
    item_o.addr   = addr_q;
    item_o.hit    = hit;
    item_o.nofree = !hit && !free_ok_q;
    item_o.slot   = hit ? map_rdata : free_slot_q;
  end

  // Command capture.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= polpq_pkg::op_e'(operation_i);
      link_q <= in_link;
      addr_q <= packet_addr_i;
    end
    free_slot_q <= free_slot_d;
  end

  // Handshake control and slot table valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q       <= 1'b0;
      lookup_q     <= 1'b0;
      free_ok_q    <= 1'b0;
      map_valid_q  <= '0;
      slot_valid_q <= '0;
    end else begin
      lookup_q  <= accept;
      free_ok_q <= free_ok_d;
      if (accept) begin
        busy_q <= 1'b1;
      end else if (done_i) begin
        busy_q <= 1'b0;
      end
      if (upd_i.clear_all) begin
        map_valid_q  <= '0;
        slot_valid_q <= '0;
      end else if (upd_i.claim) begin
        map_valid_q[upd_i.link]  <= 1'b1;
        slot_valid_q[upd_i.slot] <= 1'b1;
      end else if (upd_i.free) begin
        map_valid_q[upd_i.link]  <= 1'b0;
        slot_valid_q[upd_i.slot] <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/polpq_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// polpq_back: queue execution
// Reads the slot record, updates head, tail and depth, writes or reads the
// packet store, and produces the one-cycle result transaction.
// ----------------------------------------------------------------------------
module polpq_back (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    empty_i,
  input  wire polpq_pkg::item_t  item_i,
  output logic                   pop_o,
  output polpq_pkg::upd_t        upd_o,
  output logic                   done_o,
  output logic [2:0]             status_o,
  output logic [31:0]            popped_o,
  output logic [7:0]             count_o
);

  typedef enum logic [2:0] {
    BK_IDLE    = 3'b001,
    BK_EXEC    = 3'b010,
    BK_POPWAIT = 3'b100
  } bk_state_e;

  bk_state_e             state_q, state_d;
  polpq_pkg::item_t      item_q;
  polpq_pkg::slot_rec_t  rec_rdata, cur, rec_wdata;
  logic                  rec_we, pkt_we, pkt_rd;
  logic [31:0]           pkt_rdata;
  polpq_pkg::status_e    status_d;
  polpq_pkg::depth_t     count_d;
  polpq_pkg::upd_t       upd_d;
  logic                  done_q;
  logic [2:0]            status_q;
  logic [31:0]           popped_q;
  logic [7:0]            count_q;

  assign pop_o = (state_q == BK_IDLE) && !empty_i;

  // Slot records: depth, head and tail per slot.
  polpq_ram #(
    .WIDTH ($bits(polpq_pkg::slot_rec_t)),
    .DEPTH (polpq_pkg::QUEUE_SLOTS)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (rec_we),
    .waddr_i (item_q.slot),
    .wdata_i (rec_wdata),
    .raddr_i (item_i.slot),
    .rdata_o (rec_rdata)
  );

  // Packet store, one ring of QUEUE_DEPTH addresses per slot.
  polpq_ram #(
    .WIDTH (32),
    .DEPTH (polpq_pkg::PKT_DEPTH)
  ) u_pkts (
    .clk_i   (clk_i),
    .we_i    (pkt_we),
    .waddr_i ({item_q.slot, cur.tail}),
    .wdata_i (item_q.addr),
    .raddr_i ({item_q.slot, cur.head}),
    .rdata_o (pkt_rdata)
  );

  // A newly claimed slot starts empty, whatever its record holds.
  assign cur = item_q.hit ? rec_rdata : '0;

  // Operation decode and slot record update.
  always_comb begin
    rec_we    = 1'b0;
    rec_wdata = cur;
    pkt_we    = 1'b0;
    pkt_rd    = 1'b0;
    status_d  = polpq_pkg::ST_OK;
    count_d   = '0;
    upd_d     = '0;
    upd_d.slot = item_q.slot;
    upd_d.link = item_q.link;
    case (item_q.op)
      polpq_pkg::OP_PUSH: begin
        if (item_q.link == '0) begin
          status_d = polpq_pkg::ST_NO_ROUTE;
        end else if (item_q.nofree) begin
          status_d = polpq_pkg::ST_NO_SLOT;
        end else if (cur.depth == polpq_pkg::depth_t'(polpq_pkg::QUEUE_DEPTH)) begin
          status_d = polpq_pkg::ST_FULL;
          count_d  = cur.depth;
        end else begin
          pkt_we          = 1'b1;
          rec_we          = 1'b1;
          rec_wdata.tail  = polpq_pkg::next_pos(cur.tail);
          rec_wdata.depth = polpq_pkg::depth_t'(cur.depth + 1'b1);
          count_d         = rec_wdata.depth;
          upd_d.claim     = !item_q.hit;
        end
      end
      polpq_pkg::OP_POP: begin
        if (!item_q.hit) begin
          status_d = polpq_pkg::ST_ABSENT;
        end else if (cur.depth == '0) begin
          status_d   = polpq_pkg::ST_ABSENT;
          upd_d.free = 1'b1;
        end else begin
          pkt_rd          = 1'b1;
          rec_we          = 1'b1;
          rec_wdata.head  = polpq_pkg::next_pos(cur.head);
          rec_wdata.depth = polpq_pkg::depth_t'(cur.depth - 1'b1);
          count_d         = rec_wdata.depth;
          upd_d.free      = (rec_wdata.depth == '0);
        end
      end
      polpq_pkg::OP_QUERY: begin
        if (item_q.hit) begin
          count_d = cur.depth;
        end else begin
          status_d = polpq_pkg::ST_ABSENT;
        end
      end
      default: begin
        upd_d.clear_all = 1'b1;
      end
    endcase
    if (state_q != BK_EXEC) begin
      rec_we = 1'b0;
      pkt_we = 1'b0;
      upd_d.claim     = 1'b0;
      upd_d.free      = 1'b0;
      upd_d.clear_all = 1'b0;
    end
  end

  assign upd_o = upd_d;

  // Sequencer: take an item, execute it, wait for the packet read on a pop.
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE:    if (!empty_i) state_d = BK_EXEC;
      BK_EXEC:    state_d = pkt_rd ? BK_POPWAIT : BK_IDLE;
      BK_POPWAIT: state_d = BK_IDLE;
      default:    state_d = BK_IDLE;
    endcase
  end

  // Item and result payload registers.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      item_q <= item_i;
    end
    if (state_q == BK_EXEC) begin
      status_q <= status_d;
      count_q  <= 8'(count_d);
      popped_q <= '0;
    end else if (state_q == BK_POPWAIT) begin
      popped_q <= pkt_rdata;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= ((state_q == BK_EXEC) && !pkt_rd) || (state_q == BK_POPWAIT);
    end
  end

  assign done_o   = done_q;
  assign status_o = status_q;
  assign popped_o = popped_q;
  assign count_o  = count_q;

  // A result strobe lasts one cycle; one item is in the back end at a time.
  a_done_pulse : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("result strobe held for more than one cycle");

  // A slot is never claimed and freed by the same operation.
  a_claim_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(upd_d.claim && upd_d.free))
    else $error("slot claimed and freed together");

  // A pop that reads the packet store delivers its result once the BK_POPWAIT state has passed.
  a_pop_timing : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_EXEC && pkt_rd) |=> ##1 done_q)
    else $error("pop result not delivered on time");

  // Status codes that report a missing queue carry a zero count.
  a_absent_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && (status_q == polpq_pkg::ST_ABSENT || status_q == polpq_pkg::ST_NO_ROUTE))
      |-> (count_q == 8'd0))
    else $error("nonzero count with absent queue");

endmodule
`default_nettype wire
